>>> hdl/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants, types and codes for the memory map bus decoder.
// ----------------------------------------------------------------------------
package mmbd_pkg;

    // store depths
    localparam int CART_DEPTH = 32768;
    localparam int BOOT_DEPTH = 16384;
    localparam int BANK_DEPTH = 8192;

    // ROM store: cartridge bytes first, boot bytes above them
    localparam int ROM_DEPTH = CART_DEPTH + BOOT_DEPTH;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);
    localparam int BOOT_BASE = CART_DEPTH;

    // RAM store: video, external, work banks, then the top page
    // (sprite table, IO, high RAM) indexed by address bits [8:0]
    localparam int TOP_SPAN  = 512;
    localparam int BANK_AW   = $clog2(BANK_DEPTH);
    localparam int VRAM_BASE = 0;
    localparam int XRAM_BASE = BANK_DEPTH;
    localparam int WRAM_BASE = 2 * BANK_DEPTH;
    localparam int TOP_BASE  = 3 * BANK_DEPTH;
    localparam int RAM_DEPTH = TOP_BASE + TOP_SPAN;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int TOP_AW    = $clog2(TOP_SPAN);

    // bus map
    localparam logic [15:0] ADDR_VRAM   = 16'h8000;
    localparam logic [15:0] ADDR_XRAM   = 16'hA000;
    localparam logic [15:0] ADDR_WRAM   = 16'hC000;
    localparam logic [15:0] ADDR_ECHO   = 16'hE000;
    localparam logic [15:0] ADDR_OAM    = 16'hFE00;
    localparam logic [15:0] ADDR_GAP    = 16'hFEA0;
    localparam logic [15:0] ADDR_IO     = 16'hFF00;
    localparam logic [15:0] ADDR_BOOTOFF = 16'hFF50;
    localparam logic [15:0] ADDR_IE     = 16'hFFFF;
    localparam logic [7:0]  BYTE_OPEN   = 8'hFF;

    // boot windows / allowed lengths
    localparam logic [14:0] BOOT_LEN_MONO = 15'h0100;
    localparam logic [14:0] BOOT_LEN_CLR  = 15'h0900;
    localparam logic [14:0] BOOT_LEN_ADV  = 15'h4000;

    // access modes
    localparam logic [1:0] MODE_READ = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD_CART = 2'd2;
    localparam logic [1:0] MODE_LOAD_BOOT = 2'd3;

    // system kinds
    localparam logic [1:0] KIND_CLR = 2'd1;
    localparam logic [1:0] KIND_ADV = 2'd2;

    // config register indexes
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_SYSTEM_KIND = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROM_LENGTH  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BOOT_LENGTH = 2'd2;

    // read data source
    typedef enum logic [2:0] {
        SRC_BYTE = 3'b001,
        SRC_ROM  = 3'b010,
        SRC_RAM  = 3'b100
    } src_t;

    typedef struct packed {
        logic [1:0]  system_kind;
        logic [15:0] rom_length;
        logic [14:0] boot_rom_length;
    } cfg_t;

    typedef struct packed {
        logic              rom_en;
        logic              rom_we;
        logic [ROM_AW-1:0] rom_addr;
        logic              ram_en;
        logic              ram_we;
        logic [RAM_AW-1:0] ram_addr;
        logic              ie_we;
        logic              overlay_clear;
        src_t              src;
        logic [7:0]        byte_val;
    } dec_t;

endpackage

>>> hdl/memory_map_bus_decoder.sv
// ----------------------------------------------------------------------------
// memory_map_bus_decoder
// 16-bit handheld CPU bus decode onto a ROM store and a RAM store.
// ----------------------------------------------------------------------------
// Pipeline: stage 1 (store read), then the output register; m_tready low stalls both.
// Throughput: one beat per cycle unless stalled, set by single-port ROM and RAM stores.
// Reset: RAM store is cleared by a sweep over all RAM_DEPTH (25088) entries, one entry
// a cycle; s_tready stays low meanwhile. Config writes are taken at any time.
// Overlay comes up mapped, IE and config registers come up zero.
// ----------------------------------------------------------------------------
module memory_map_bus_decoder (
    input  logic                          clk,
    input  logic                          rst_n,

    // config write port
    input  logic                          cfg_we,
    input  logic [mmbd_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [mmbd_pkg::CFG_DW-1:0]   cfg_data,

    // access stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]                    s_tuser,   // [1:0] mode

    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata    // [7:0] read_data, [8] overlay_on,
                                                     // [9] config_valid, [15:10] zero
);

    import mmbd_pkg::*;

    // config registers
    logic [1:0]  system_kind_reg;
    logic [15:0] rom_length_reg;
    logic [14:0] boot_rom_length_reg;
    cfg_t        cfg;

    // bus-visible state outside the stores
    logic        overlay_reg;
    logic [7:0]  ie_reg;

    // clearing sweep
    logic              clr_busy_reg;
    logic [RAM_AW-1:0] clr_cnt_reg;

    // stage 1: store read in flight
    logic        s1_valid_reg;
    src_t        s1_src_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_overlay_reg;
    logic        s1_cfg_ok_reg;
    logic        s1_move;

    // output register
    logic        m_valid_reg;
    logic [7:0]  m_rd_reg;
    logic        m_overlay_reg;
    logic        m_cfg_ok_reg;

    dec_t        dec;
    logic        cfg_ok;
    logic        accept;
    logic [7:0]  rom_rdata;
    logic [7:0]  ram_rdata;
    logic [7:0]  s1_rd;

    // RAM port mux
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;

    assign cfg.system_kind     = system_kind_reg;
    assign cfg.rom_length      = rom_length_reg;
    assign cfg.boot_rom_length = boot_rom_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            system_kind_reg     <= '0;
            rom_length_reg      <= '0;
            boot_rom_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYSTEM_KIND: system_kind_reg     <= cfg_data[1:0];
                CFG_ROM_LENGTH:  rom_length_reg      <= cfg_data;
                CFG_BOOT_LENGTH: boot_rom_length_reg <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    mmbd_decode u_decode (
        .mode       (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .cfg        (cfg),
        .overlay    (overlay_reg),
        .ie_value   (ie_reg),
        .dec        (dec),
        .cfg_ok     (cfg_ok)
    );

    // stage 1 can move when the output register is free or being drained
    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || s1_move);
    assign accept   = s_tvalid && s_tready;

    // cartridge + boot bytes; never cleared
    mmbd_ram #(
        .DEPTH (ROM_DEPTH),
        .WIDTH (8)
    ) u_rom (
        .clk   (clk),
        .en    (accept && dec.rom_en),
        .we    (dec.rom_we),
        .addr  (dec.rom_addr),
        .wdata (s_tdata[23:16]),
        .rdata (rom_rdata)
    );

    // sweep owns the RAM port until the clear is done
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_cnt_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_en    = accept && dec.ram_en;
            ram_we    = dec.ram_we;
            ram_addr  = dec.ram_addr;
            ram_wdata = s_tdata[23:16];
        end
    end

    mmbd_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == RAM_AW'(RAM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // overlay drop and IE write land with the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_reg <= 1'b1;
            ie_reg      <= 8'd0;
        end
        else if (accept)
        begin
            if (dec.overlay_clear)
            begin
                overlay_reg <= 1'b0;
            end
            if (dec.ie_we)
            begin
                ie_reg <= s_tdata[23:16];
            end
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload; store rdata holds since no new read is issued while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg     <= dec.src;
            s1_byte_reg    <= dec.byte_val;
            s1_overlay_reg <= overlay_reg && !dec.overlay_clear;
            s1_cfg_ok_reg  <= cfg_ok;
        end
    end

    always_comb
    begin
        case (s1_src_reg)
            SRC_ROM: s1_rd = rom_rdata;
            SRC_RAM: s1_rd = ram_rdata;
            default: s1_rd = s1_byte_reg;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_rd_reg      <= s1_rd;
            m_overlay_reg <= s1_overlay_reg;
            m_cfg_ok_reg  <= s1_cfg_ok_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_cfg_ok_reg, m_overlay_reg, m_rd_reg};

endmodule

>>> hdl/mmbd_ram.sv
// ----------------------------------------------------------------------------
// mmbd_ram
// Single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module mmbd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

>>> hdl/mmbd_decode.sv
// ----------------------------------------------------------------------------
// mmbd_decode
// Address decode of one access into ROM/RAM port requests and side effects.
// ----------------------------------------------------------------------------
module mmbd_decode (
    input  logic [1:0]           mode,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    input  mmbd_pkg::cfg_t       cfg,
    input  logic                 overlay,
    input  logic [7:0]           ie_value,
    output mmbd_pkg::dec_t       dec,
    output logic                 cfg_ok
);

    import mmbd_pkg::*;

    logic [14:0]       boot_window;
    logic              boot_hit;
    logic              cart_hit;
    logic              ram_hit;
    logic [RAM_AW-1:0] ram_idx;

    always_comb
    begin
        case (cfg.system_kind)
            KIND_ADV: boot_window = BOOT_LEN_ADV;
            KIND_CLR: boot_window = BOOT_LEN_CLR;
            default:  boot_window = BOOT_LEN_MONO;
        endcase

        case (cfg.system_kind)
            KIND_ADV: cfg_ok = (cfg.boot_rom_length == BOOT_LEN_ADV);
            KIND_CLR: cfg_ok = (cfg.boot_rom_length == BOOT_LEN_CLR);
            default:  cfg_ok = (cfg.boot_rom_length == BOOT_LEN_MONO)
                            || (cfg.boot_rom_length == BOOT_LEN_CLR);
        endcase
        cfg_ok = cfg_ok && (cfg.rom_length != 16'd0);
    end

    assign boot_hit = overlay
                   && (address < 16'(boot_window))
                   && (address < 16'(cfg.boot_rom_length))
                   && (32'(address) < BOOT_DEPTH);
    assign cart_hit = (address < cfg.rom_length) && (32'(address) < CART_DEPTH);

    // RAM-backed regions; sprite/IO/high share the top page
    always_comb
    begin
        ram_hit = 1'b1;
        ram_idx = '0;
        if (address < ADDR_VRAM)
        begin
            ram_hit = 1'b0;
        end
        else if (address < ADDR_XRAM)
        begin
            ram_idx = RAM_AW'(VRAM_BASE) + RAM_AW'(address[BANK_AW-1:0]);
        end
        else if (address < ADDR_WRAM)
        begin
            ram_idx = RAM_AW'(XRAM_BASE) + RAM_AW'(address[BANK_AW-1:0]);
        end
        else if (address < ADDR_OAM)
        begin
            // work RAM and its echo
            ram_idx = RAM_AW'(WRAM_BASE) + RAM_AW'(address[BANK_AW-1:0]);
        end
        else if ((address < ADDR_GAP) || ((address >= ADDR_IO) && (address != ADDR_IE)))
        begin
            ram_idx = RAM_AW'(TOP_BASE) + RAM_AW'(address[TOP_AW-1:0]);
        end
        else
        begin
            ram_hit = 1'b0;
        end
    end

    always_comb
    begin
        dec               = '0;
        dec.src           = SRC_BYTE;
        dec.byte_val      = 8'd0;
        dec.ram_addr      = ram_idx;
        case (mode)
            MODE_READ:
            begin
                if (boot_hit)
                begin
                    dec.rom_en   = 1'b1;
                    dec.rom_addr = ROM_AW'(BOOT_BASE) + ROM_AW'(address);
                    dec.src      = SRC_ROM;
                end
                else if (address < ADDR_VRAM)
                begin
                    if (cart_hit)
                    begin
                        dec.rom_en   = 1'b1;
                        dec.rom_addr = ROM_AW'(address);
                        dec.src      = SRC_ROM;
                    end
                    else
                    begin
                        dec.byte_val = BYTE_OPEN;
                    end
                end
                else if (ram_hit)
                begin
                    dec.ram_en = 1'b1;
                    dec.src    = SRC_RAM;
                end
                else if (address == ADDR_IE)
                begin
                    dec.byte_val = ie_value;
                end
                else
                begin
                    dec.byte_val = BYTE_OPEN;
                end
            end
            MODE_WRITE:
            begin
                dec.ram_en        = ram_hit;
                dec.ram_we        = ram_hit;
                dec.ie_we         = (address == ADDR_IE);
                dec.overlay_clear = (address == ADDR_BOOTOFF) && (write_data != 8'd0);
            end
            MODE_LOAD_CART:
            begin
                dec.rom_en   = (32'(address) < CART_DEPTH);
                dec.rom_we   = dec.rom_en;
                dec.rom_addr = ROM_AW'(address);
            end
            MODE_LOAD_BOOT:
            begin
                dec.rom_en   = (32'(address) < BOOT_DEPTH);
                dec.rom_we   = dec.rom_en;
                dec.rom_addr = ROM_AW'(BOOT_BASE) + ROM_AW'(address);
            end
            default:
            begin
                dec.src = SRC_BYTE;
            end
        endcase
    end

endmodule
